>>> design/cba_pkg.sv
// shared types and constants for the clipped alpha blender
`timescale 1ns / 1ps

package cba_pkg;

   // largest overlay or frame size honored by the clipping logic
   localparam int MAX_SIZE = 8192;

   // request queue between classifier and blend pipeline
   localparam int QUEUE_DEPTH = 4;

   // configuration register indexes
   localparam logic [2:0] CSR_OFFSET_X      = 3'd0;
   localparam logic [2:0] CSR_OFFSET_Y      = 3'd1;
   localparam logic [2:0] CSR_FRAME_WIDTH   = 3'd2;
   localparam logic [2:0] CSR_FRAME_HEIGHT  = 3'd3;
   localparam logic [2:0] CSR_SOURCE_WIDTH  = 3'd4;
   localparam logic [2:0] CSR_SOURCE_HEIGHT = 3'd5;
   localparam logic [2:0] CSR_GLOBAL_ALPHA  = 3'd6;

   // clipping settings seen by the classifier
   typedef struct packed {
      logic signed [13:0] offset_x;
      logic signed [13:0] offset_y;
      logic [13:0]        frame_width;
      logic [13:0]        frame_height;
      logic [13:0]        source_width;
      logic [13:0]        source_height;
   } clip_cfg_type;

   // one visible pixel waiting to be blended
   typedef struct packed {
      logic [12:0] frame_x;
      logic [12:0] frame_y;
      logic [7:0]  src_red;
      logic [7:0]  src_green;
      logic [7:0]  src_blue;
      logic [7:0]  overlay_alpha;
      logic [7:0]  back_red;
      logic [7:0]  back_green;
      logic [7:0]  back_blue;
   } pixel_type;

endpackage

>>> design/cba_front.sv
// front end: unpacks request transactions and drops pixels that fall outside the frame
`timescale 1ns / 1ps

module cba_front (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [87:0]           req_tdata,
   input  cba_pkg::clip_cfg_type clip_cfg,
   input  logic                  queue_full,
   output logic                  queue_push,
   output cba_pkg::pixel_type    queue_item
);
   import cba_pkg::*;

   localparam logic [13:0] SIZE_CAP = 14'(MAX_SIZE);

   logic [12:0]        src_x;
   logic [12:0]        src_y;
   logic signed [14:0] pos_x;
   logic signed [14:0] pos_y;
   logic               inside_source;
   logic               inside_frame;

   // registers above the size cap act as the cap
   function automatic logic [13:0] cap_size(input logic [13:0] v);
      cap_size = (v > SIZE_CAP) ? SIZE_CAP : v;
   endfunction

   // overlay position fields
   assign src_x = req_tdata[12:0];
   assign src_y = req_tdata[25:13];

   // frame position is overlay position plus signed offset
   assign pos_x = 15'(signed'(clip_cfg.offset_x)) + signed'({2'b00, src_x});
   assign pos_y = 15'(signed'(clip_cfg.offset_y)) + signed'({2'b00, src_y});

   // clip against overlay size, frame size and coordinate range
   always_comb begin
      inside_source = ({1'b0, src_x} < cap_size(clip_cfg.source_width)) &&
                      ({1'b0, src_y} < cap_size(clip_cfg.source_height));
      inside_frame  = !pos_x[14] && !pos_x[13] && !pos_y[14] && !pos_y[13] &&
                      ({1'b0, pos_x[12:0]} < cap_size(clip_cfg.frame_width)) &&
                      ({1'b0, pos_y[12:0]} < cap_size(clip_cfg.frame_height));
   end

   // dropped pixels are taken and discarded; visible ones go to the queue
   assign req_tready = !queue_full;
   assign queue_push = req_tvalid && !queue_full && inside_source && inside_frame;

   always_comb begin
      queue_item.frame_x       = pos_x[12:0];
      queue_item.frame_y       = pos_y[12:0];
      queue_item.src_red       = req_tdata[33:26];
      queue_item.src_green     = req_tdata[41:34];
      queue_item.src_blue      = req_tdata[49:42];
      queue_item.overlay_alpha = req_tdata[57:50];
      queue_item.back_red      = req_tdata[65:58];
      queue_item.back_green    = req_tdata[73:66];
      queue_item.back_blue     = req_tdata[81:74];
   end

endmodule

>>> design/cba_queue.sv
// short queue of visible pixels between the front end and the blend pipeline
`timescale 1ns / 1ps

module cba_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cba_pkg::pixel_type push_item,
   input  logic               pop,
   output cba_pkg::pixel_type head_item,
   output logic               full,
   output logic               empty
);
   import cba_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   pixel_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [PTR_W:0]    count_ff;
   logic [PTR_W:0]    count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> design/cba_blend.sv
// blend pipeline: global alpha scaling, channel mixing and the result register
`timescale 1ns / 1ps

module cba_blend (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         global_alpha,
   input  logic               queue_empty,
   input  cba_pkg::pixel_type queue_item,
   output logic               queue_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [55:0]        rsp_tdata
);
   import cba_pkg::*;

   localparam logic [7:0] FULL = 8'd255;

   logic        advance;
   // stage 1: alpha product
   logic        s1_valid_ff;
   pixel_type   s1_item_ff;
   logic [15:0] s1_alpha_prod_ff;
   // stage 2: effective alpha
   logic        s2_valid_ff;
   pixel_type   s2_item_ff;
   logic [7:0]  s2_alpha_ff;
   // stage 3: weighted sums
   logic        s3_valid_ff;
   logic [12:0] s3_frame_x_ff;
   logic [12:0] s3_frame_y_ff;
   logic [15:0] s3_sum_red_ff;
   logic [15:0] s3_sum_green_ff;
   logic [15:0] s3_sum_blue_ff;
   logic [7:0]  s2_inv_alpha;
   // result register
   logic        rsp_valid_ff;
   logic [12:0] rsp_frame_x_ff;
   logic [12:0] rsp_frame_y_ff;
   logic [7:0]  rsp_red_ff;
   logic [7:0]  rsp_green_ff;
   logic [7:0]  rsp_blue_ff;

   // exact truncating divide by 255 for values up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [15:0] t;
      t = x + {8'd0, x[15:8]} + 16'd1;
      div255 = t[15:8];
   endfunction

   // whole pipeline moves when the result register is free or being taken
   assign advance   = !rsp_valid_ff || rsp_tready;
   assign queue_pop = advance && !queue_empty;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= !queue_empty;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   assign s2_inv_alpha = FULL - s2_alpha_ff;

   // data path
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff       <= queue_item;
         s1_alpha_prod_ff <= queue_item.overlay_alpha * global_alpha;

         s2_item_ff       <= s1_item_ff;
         s2_alpha_ff      <= div255(s1_alpha_prod_ff);

         s3_frame_x_ff    <= s2_item_ff.frame_x;
         s3_frame_y_ff    <= s2_item_ff.frame_y;
         s3_sum_red_ff    <= s2_item_ff.src_red * s2_alpha_ff +
                             s2_item_ff.back_red * s2_inv_alpha;
         s3_sum_green_ff  <= s2_item_ff.src_green * s2_alpha_ff +
                             s2_item_ff.back_green * s2_inv_alpha;
         s3_sum_blue_ff   <= s2_item_ff.src_blue * s2_alpha_ff +
                             s2_item_ff.back_blue * s2_inv_alpha;

         rsp_frame_x_ff   <= s3_frame_x_ff;
         rsp_frame_y_ff   <= s3_frame_y_ff;
         rsp_red_ff       <= div255(s3_sum_red_ff);
         rsp_green_ff     <= div255(s3_sum_green_ff);
         rsp_blue_ff      <= div255(s3_sum_blue_ff);
      end
   end

   // result transaction
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_blue_ff, rsp_green_ff, rsp_red_ff,
                        rsp_frame_y_ff, rsp_frame_x_ff};

endmodule

>>> design/clipped_alpha_blender.sv
// top level of the clipped alpha blender: configuration registers and block wiring
`timescale 1ns / 1ps

// Lays an RGBA overlay pixel over the background pixel under it, with a global
// opacity on top of the pixel alpha. Each request transaction carries one overlay
// pixel, its overlay position and the background colour; the frame position is the
// overlay position plus the signed offset. Pixels outside the overlay size, the
// frame size or the 13-bit coordinate range are taken and produce no response.
// The block takes one pixel per clock while the queue has room: the front end
// clips in the cycle of acceptance and writes visible pixels into a 4-entry
// queue, and a four-stage blend pipeline (alpha product, alpha divide, channel
// mixing, divide into the result register) drains it. A stalled response stalls
// the pipeline; requests keep being accepted until the queue fills. The user must
// write configuration only while idle; the block itself does not enforce it.

module clipped_alpha_blender (
   input  logic        clock,
   input  logic        reset,
   // request: src_x, src_y, src_red, src_green, src_blue, overlay_alpha,
   // back_red, back_green, back_blue, zero pad
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,
   // response: frame_x, frame_y, out_red, out_green, out_blue, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   // configuration writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_wdata
);
   import cba_pkg::*;

   clip_cfg_type clip_cfg_ff;
   logic [7:0]   global_alpha_ff;
   logic         queue_full;
   logic         queue_empty;
   logic         queue_push;
   logic         queue_pop;
   pixel_type    push_item;
   pixel_type    head_item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_cfg_ff.offset_x      <= 14'sd0;
         clip_cfg_ff.offset_y      <= 14'sd0;
         clip_cfg_ff.frame_width   <= 14'd1024;
         clip_cfg_ff.frame_height  <= 14'd768;
         clip_cfg_ff.source_width  <= 14'd1024;
         clip_cfg_ff.source_height <= 14'd768;
         global_alpha_ff           <= 8'd255;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OFFSET_X:      clip_cfg_ff.offset_x      <= signed'(csr_wdata);
            CSR_OFFSET_Y:      clip_cfg_ff.offset_y      <= signed'(csr_wdata);
            CSR_FRAME_WIDTH:   clip_cfg_ff.frame_width   <= csr_wdata;
            CSR_FRAME_HEIGHT:  clip_cfg_ff.frame_height  <= csr_wdata;
            CSR_SOURCE_WIDTH:  clip_cfg_ff.source_width  <= csr_wdata;
            CSR_SOURCE_HEIGHT: clip_cfg_ff.source_height <= csr_wdata;
            CSR_GLOBAL_ALPHA:  global_alpha_ff           <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // clipping front end
   cba_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .clip_cfg   (clip_cfg_ff),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_item (push_item)
   );

   // visible pixel queue
   cba_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (push_item),
      .pop       (queue_pop),
      .head_item (head_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // blend pipeline
   cba_blend u_blend (
      .clock        (clock),
      .reset        (reset),
      .global_alpha (global_alpha_ff),
      .queue_empty  (queue_empty),
      .queue_item   (head_item),
      .queue_pop    (queue_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

>>> verif/blend_checker.sv
// checker for the clipped alpha blender: register mirror, blend prediction and response compare
`timescale 1ns / 1ps

module blend_checker (
   input  logic        clock,
   input  logic        reset,
   // request: src_x, src_y, src_red, src_green, src_blue, overlay_alpha,
   // back_red, back_green, back_blue, zero pad
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [87:0] req_tdata,
   // response: frame_x, frame_y, out_red, out_green, out_blue, zero pad
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_wdata,
   output int          error_count,
   output int          pending
);
   import cba_pkg::*;

   localparam int FULL_SCALE  = 255;
   localparam int COORD_LIMIT = 8192;

   typedef struct packed {
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [12:0] frame_y;
      logic [12:0] frame_x;
   } blended_pixel_type;

   blended_pixel_type blended_pixels[$];

   // mirrored configuration registers
   logic signed [13:0] offset_x;
   logic signed [13:0] offset_y;
   logic [13:0]        frame_width;
   logic [13:0]        frame_height;
   logic [13:0]        source_width;
   logic [13:0]        source_height;
   logic [7:0]         global_alpha;

   // sizes above the supported maximum behave as the maximum
   function automatic int capped(logic [13:0] size);
      return (int'(size) > MAX_SIZE) ? MAX_SIZE : int'(size);
   endfunction

   function automatic logic [7:0] mix_channel(int src, int back, int alpha);
      return 8'((src * alpha + back * (FULL_SCALE - alpha)) / FULL_SCALE);
   endfunction

   // clip the pixel, then blend it; returns 0 when the pixel is dropped
   function automatic bit blend_pixel(input logic [87:0] data,
                                      output blended_pixel_type pixel);
      int sx;
      int sy;
      int fx;
      int fy;
      int alpha;
      pixel = '0;
      sx = int'(data[12:0]);
      sy = int'(data[25:13]);
      if (sx >= capped(source_width) || sy >= capped(source_height))
         return 0;
      fx = int'(offset_x) + sx;
      fy = int'(offset_y) + sy;
      if (fx < 0 || fy < 0)
         return 0;
      if (fx >= capped(frame_width) || fy >= capped(frame_height))
         return 0;
      if (fx >= COORD_LIMIT || fy >= COORD_LIMIT)
         return 0;
      alpha = (int'(data[57:50]) * int'(global_alpha)) / FULL_SCALE;
      pixel.frame_x = fx[12:0];
      pixel.frame_y = fy[12:0];
      pixel.red     = mix_channel(int'(data[33:26]), int'(data[65:58]), alpha);
      pixel.green   = mix_channel(int'(data[41:34]), int'(data[73:66]), alpha);
      pixel.blue    = mix_channel(int'(data[49:42]), int'(data[81:74]), alpha);
      return 1;
   endfunction

   task automatic report_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   // watch all three ports at each rising edge
   always @(posedge clock) begin : monitor
      blended_pixel_type expected;
      blended_pixel_type observed;
      if (reset) begin
         blended_pixels.delete();
         error_count   = 0;
         offset_x      = '0;
         offset_y      = '0;
         frame_width   = 14'd1024;
         frame_height  = 14'd768;
         source_width  = 14'd1024;
         source_height = 14'd768;
         global_alpha  = 8'd255;
      end else begin
         // response transaction against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            observed = rsp_tdata[49:0];
            if (blended_pixels.size() == 0) begin
               report_mismatch($sformatf("response (%0d,%0d) with nothing expected",
                                         observed.frame_x, observed.frame_y));
            end else begin
               expected = blended_pixels.pop_front();
               if (observed.frame_x !== expected.frame_x)
                  report_mismatch($sformatf("frame_x got %0d expected %0d",
                                            observed.frame_x, expected.frame_x));
               if (observed.frame_y !== expected.frame_y)
                  report_mismatch($sformatf("frame_y got %0d expected %0d",
                                            observed.frame_y, expected.frame_y));
               if (observed.red !== expected.red)
                  report_mismatch($sformatf("out_red got %0d expected %0d",
                                            observed.red, expected.red));
               if (observed.green !== expected.green)
                  report_mismatch($sformatf("out_green got %0d expected %0d",
                                            observed.green, expected.green));
               if (observed.blue !== expected.blue)
                  report_mismatch($sformatf("out_blue got %0d expected %0d",
                                            observed.blue, expected.blue));
            end
         end
         // request transaction: predict the blended pixel, if any
         if (req_tvalid && req_tready && blend_pixel(req_tdata, expected))
            blended_pixels.push_back(expected);
         // register writes; unknown index is ignored
         if (csr_we) begin
            case (csr_index)
               CSR_OFFSET_X:      offset_x      = csr_wdata;
               CSR_OFFSET_Y:      offset_y      = csr_wdata;
               CSR_FRAME_WIDTH:   frame_width   = csr_wdata;
               CSR_FRAME_HEIGHT:  frame_height  = csr_wdata;
               CSR_SOURCE_WIDTH:  source_width  = csr_wdata;
               CSR_SOURCE_HEIGHT: source_height = csr_wdata;
               CSR_GLOBAL_ALPHA:  global_alpha  = csr_wdata[7:0];
               default: ;
            endcase
         end
      end
      pending = blended_pixels.size();
   end

endmodule

>>> verif/testbench.sv
// top of the clipped alpha blender testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
   import cba_pkg::*;

   localparam int          CLOCK_HALF      = 4;
   localparam int          RESET_CYCLES    = 6;
   localparam int          SETTLE_CYCLES   = 12;
   localparam int          WATCHDOG_LIMIT  = 2000;
   localparam int          ITEMS_PER_SETUP = 190;
   localparam logic [2:0]  CSR_UNUSED      = 3'd7;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = CSR_OFFSET_X;
   logic [13:0] csr_wdata  = '0;

   int error_count;
   int pending;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int span_x        = 1031;
   int span_y        = 775;
   int stall_cycles  = 0;

   always #CLOCK_HALF clock = ~clock;

   clipped_alpha_blender dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   blend_checker blend_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .pending     (pending)
   );

   // receiver backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // one pixel transaction, with random idle cycles ahead of it
   task automatic send_pixel(input logic [12:0] x, input logic [12:0] y,
                             input logic [7:0] sr, input logic [7:0] sg,
                             input logic [7:0] sb, input logic [7:0] sa,
                             input logic [7:0] br, input logic [7:0] bg,
                             input logic [7:0] bb);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, bb, bg, br, sa, sb, sg, sr, y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [7:0] pick_alpha();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // mostly positions near the overlay, some anywhere in the 13-bit range
   task automatic send_random_pixel();
      logic [12:0] x;
      logic [12:0] y;
      x = ($urandom_range(99) < 85) ? 13'($urandom_range(span_x)) : 13'($urandom_range(8191));
      y = ($urandom_range(99) < 85) ? 13'($urandom_range(span_y)) : 13'($urandom_range(8191));
      send_pixel(x, y, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), pick_alpha(), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   // stop sending and let every outstanding response drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // full register setup, plus a write to the unused index that must be ignored
   task automatic write_config(input int ox, input int oy, input int fw, input int fh,
                               input int sw, input int sh, input int ga);
      logic [2:0]  indexes[8];
      logic [13:0] values[8];
      indexes = '{CSR_OFFSET_X, CSR_OFFSET_Y, CSR_FRAME_WIDTH, CSR_FRAME_HEIGHT,
                  CSR_SOURCE_WIDTH, CSR_SOURCE_HEIGHT, CSR_GLOBAL_ALPHA, CSR_UNUSED};
      values  = '{14'(ox), 14'(oy), 14'(fw), 14'(fh), 14'(sw), 14'(sh), 14'(ga),
                  14'($urandom_range(16383))};
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= indexes[i];
         csr_wdata <= values[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      span_x = ((sw > MAX_SIZE) ? MAX_SIZE : sw) + 8;
      span_y = ((sh > MAX_SIZE) ? MAX_SIZE : sh) + 8;
      if (span_x > 8191) span_x = 8191;
      if (span_y > 8191) span_y = 8191;
   endtask

   // random setup: compact windows give many hits, wide ones reach the extremes
   task automatic random_config(input bit wide);
      int ga;
      ga = ($urandom_range(3) == 0) ? ($urandom_range(1) * 255) : $urandom_range(255);
      if (wide)
         write_config($urandom_range(16383) - 8192, $urandom_range(16383) - 8192,
                      $urandom_range(16383), $urandom_range(16383),
                      $urandom_range(16383), $urandom_range(16383), ga);
      else
         write_config($urandom_range(95) - 32, $urandom_range(95) - 32,
                      $urandom_range(96, 1), $urandom_range(96, 1),
                      $urandom_range(64, 1), $urandom_range(64, 1), ga);
   endtask

   // no-progress watchdog
   initial begin
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: transparent, opaque, far corner, and clipped positions
      send_pixel(13'd0, 13'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
      send_pixel(13'd0, 13'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
      send_pixel(13'd1023, 13'd767, 8'd200, 8'd100, 8'd50, 8'd128, 8'd10, 8'd20, 8'd30);
      send_pixel(13'd1024, 13'd0, 8'd1, 8'd2, 8'd3, 8'd255, 8'd4, 8'd5, 8'd6);
      send_pixel(13'd0, 13'd768, 8'd1, 8'd2, 8'd3, 8'd255, 8'd4, 8'd5, 8'd6);
      send_pixel(13'd8191, 13'd8191, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0);
      wait_idle();

      // negative offsets: left and top edges of the frame
      write_config(-5, -3, 1024, 768, 1100, 800, 128);
      send_pixel(13'd4, 13'd3, 8'd9, 8'd9, 8'd9, 8'd200, 8'd1, 8'd1, 8'd1);
      send_pixel(13'd5, 13'd2, 8'd9, 8'd9, 8'd9, 8'd200, 8'd1, 8'd1, 8'd1);
      send_pixel(13'd5, 13'd3, 8'd255, 8'd128, 8'd0, 8'd255, 8'd0, 8'd128, 8'd255);
      send_pixel(13'd1028, 13'd770, 8'd77, 8'd88, 8'd99, 8'd100, 8'd11, 8'd22, 8'd33);
      wait_idle();

      // largest offset with oversized registers: one column fits, the next overflows
      write_config(8191, 0, 16383, 16383, 16383, 16383, 0);
      send_pixel(13'd0, 13'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd3, 8'd4, 8'd5);
      send_pixel(13'd1, 13'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd3, 8'd4, 8'd5);
      wait_idle();

      // overlay far corner just inside the maximum size
      write_config(-1, -1, 8192, 8192, 8192, 8192, 255);
      send_pixel(13'd8191, 13'd8191, 8'd255, 8'd255, 8'd255, 8'd254, 8'd0, 8'd0, 8'd0);
      send_pixel(13'd0, 13'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
      wait_idle();

      // most negative offset pushes everything off the frame
      write_config(-8192, -8192, 8192, 8192, 8192, 8192, 1);
      send_pixel(13'd8191, 13'd8191, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
      wait_idle();

      // zero sizes drop every pixel
      write_config(0, 0, 0, 768, 1024, 768, 255);
      send_pixel(13'd0, 13'd0, 8'd10, 8'd20, 8'd30, 8'd255, 8'd0, 8'd0, 8'd0);
      wait_idle();
      write_config(0, 0, 1024, 0, 0, 0, 200);
      send_pixel(13'd0, 13'd0, 8'd10, 8'd20, 8'd30, 8'd255, 8'd0, 8'd0, 8'd0);
      wait_idle();

      // random traffic under each idle pattern, compact and wide setups
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 45; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 45; end
            default: begin send_idle_pct = 12; rsp_stall_pct = 12; end
         endcase
         for (int setup = 0; setup < 2; setup++) begin
            wait_idle();
            random_config(setup == 1);
            for (int n = 0; n < ITEMS_PER_SETUP; n++) begin
               if ($urandom_range(149) == 0)
                  wait_idle();
               send_random_pixel();
            end
         end
      end

      wait_idle();
      if (error_count == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> clipped_alpha_blender.f
design/cba_pkg.sv
design/cba_front.sv
design/cba_queue.sv
design/cba_blend.sv
design/clipped_alpha_blender.sv
verif/blend_checker.sv
verif/testbench.sv
